### rtl/char_lcd_nibble_write_queue_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character-LCD nibble write queue
// Clocked checks on clk; the guarded form is cut off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITE_QUEUE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check a property on every edge outside reset
`define LCDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on every edge, reset included
`define LCDQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCDQ_ASSERT(lbl, prop, msg)
`define LCDQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/lcdq_pkg.sv
// ----------------------------------------------------------------------------
// lcdq_pkg
// Shared constants, request codes and the decoded operation type.
// ----------------------------------------------------------------------------
package lcdq_pkg;

    // nibble queue geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int REQ_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int COL_W   = 6;
    localparam int ENTRY_W = NIB_W + 1;

    // request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CURSOR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

    // cursor command bases and column limit
    localparam logic [BYTE_W-1:0] CURSOR_ROW0 = 8'h80;
    localparam logic [BYTE_W-1:0] CURSOR_ROW1 = 8'hC0;
    localparam logic [COL_W-1:0]  MAX_COLUMN  = 6'd39;

    // decoded operation kinds
    typedef logic [1:0] op_kind_t;
    localparam op_kind_t OP_NONE  = 2'd0;
    localparam op_kind_t OP_QUEUE = 2'd1;
    localparam op_kind_t OP_TICK  = 2'd2;

    typedef struct packed {
        op_kind_t            kind;
        logic [BYTE_W-1:0]   data;
        logic                cmd;
    } op_t;

endpackage

### rtl/lcdq_front.sv
// ----------------------------------------------------------------------------
// lcdq_front
// Accepts requests, turns push and set-cursor into one queue-byte operation,
// and buffers decoded operations in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lcdq_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lcdq_pkg::REQ_W-1:0]    req_type,
    input  logic [lcdq_pkg::BYTE_W-1:0]   byte_value,
    input  logic                          is_command,
    input  logic                          row,
    input  logic [lcdq_pkg::COL_W-1:0]    column,
    output logic                          op_valid,
    output lcdq_pkg::op_t                 op,
    input  logic                          op_ready
);

    lcdq_pkg::op_t       op_q_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          cnt_reg, cnt_next;
    lcdq_pkg::op_t       dec_op;
    logic [lcdq_pkg::COL_W-1:0]  col_clamped;
    logic [lcdq_pkg::BYTE_W-1:0] cursor_base;
    logic                push;
    logic                pop;

    // classify the request
    always_comb
    begin
        col_clamped = (column > lcdq_pkg::MAX_COLUMN) ? lcdq_pkg::MAX_COLUMN : column;
        cursor_base = row ? lcdq_pkg::CURSOR_ROW1 : lcdq_pkg::CURSOR_ROW0;
        dec_op.kind = lcdq_pkg::OP_NONE;
        dec_op.data = byte_value;
        dec_op.cmd  = is_command;
        unique case (req_type)
            lcdq_pkg::REQ_PUSH:
            begin
                dec_op.kind = lcdq_pkg::OP_QUEUE;
            end
            lcdq_pkg::REQ_CURSOR:
            begin
                dec_op.kind = lcdq_pkg::OP_QUEUE;
                dec_op.data = cursor_base + {2'b00, col_clamped};
                dec_op.cmd  = 1'b1;
            end
            lcdq_pkg::REQ_TICK:
            begin
                dec_op.kind = lcdq_pkg::OP_TICK;
            end
            default:
            begin
                dec_op.kind = lcdq_pkg::OP_NONE;
            end
        endcase
    end

    // two-entry operation queue
    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign op_valid = (cnt_reg != 2'd0);
    assign pop      = op_valid && op_ready;
    assign op       = op_q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    // advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // hold decoded operations
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q_reg[wr_ptr_reg] <= dec_op;
        end
    end

endmodule

### rtl/lcdq_back.sv
// ----------------------------------------------------------------------------
// lcdq_back
// Carries out decoded operations on the nibble memory: writes two entries for
// a queued byte with room, reads one entry for a nonempty tick, and loads the result register.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_write_queue_defines.svh"

module lcdq_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    input  lcdq_pkg::op_t                 op,
    output logic                          op_ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          accepted,
    output logic                          strobe_res,
    output logic [lcdq_pkg::NIB_W-1:0]    nibble,
    output logic                          reg_select,
    output logic [lcdq_pkg::LVL_W-1:0]    queue_level
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WR_LO = 2'd1;
    localparam logic [1:0] ST_RD    = 2'd2;

    logic [lcdq_pkg::ENTRY_W-1:0] nibble_mem [lcdq_pkg::QUEUE_DEPTH];

    logic [1:0]                   state_reg, state_next;
    logic [lcdq_pkg::IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [lcdq_pkg::IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [lcdq_pkg::LVL_W-1:0]   count_reg, count_next;
    logic                         out_valid_reg, out_valid_next;
    logic [lcdq_pkg::ENTRY_W-1:0] lo_entry_reg;
    logic [lcdq_pkg::ENTRY_W-1:0] rd_data_reg;
    logic                         acc_reg, strobe_reg, rs_reg;
    logic [lcdq_pkg::NIB_W-1:0]   nib_reg;
    logic [lcdq_pkg::LVL_W-1:0]   level_reg;

    logic                         slot_free;
    logic                         has_room;
    logic                         mem_we, mem_re, lo_load, res_load;
    logic [lcdq_pkg::ENTRY_W-1:0] mem_wdata;
    logic [lcdq_pkg::IDX_W-1:0]   wr_idx_inc, rd_idx_inc;
    logic                         res_acc, res_strobe, res_rs;
    logic [lcdq_pkg::NIB_W-1:0]   res_nib;
    logic [lcdq_pkg::LVL_W-1:0]   res_level;

    // result slot is free when empty or draining at this edge
    assign slot_free = !out_valid_reg || !out_stall;
    assign op_ready  = (state_reg == ST_IDLE) && slot_free;
    assign has_room  = (count_reg <= lcdq_pkg::LVL_W'(lcdq_pkg::QUEUE_DEPTH - 2));

    // wrap the memory indices
    assign wr_idx_inc = (wr_idx_reg == lcdq_pkg::IDX_W'(lcdq_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : wr_idx_reg + lcdq_pkg::IDX_W'(1);
    assign rd_idx_inc = (rd_idx_reg == lcdq_pkg::IDX_W'(lcdq_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : rd_idx_reg + lcdq_pkg::IDX_W'(1);

    // sequence one operation
    always_comb
    begin
        state_next     = state_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = lo_entry_reg;
        lo_load        = 1'b0;
        res_load       = 1'b0;
        res_acc        = 1'b0;
        res_strobe     = 1'b0;
        res_nib        = '0;
        res_rs         = 1'b0;
        res_level      = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid && op_ready)
                begin
                    unique case (op.kind)
                        lcdq_pkg::OP_QUEUE:
                        begin
                            if (has_room)
                            begin
                                mem_we      = 1'b1;
                                mem_wdata   = {op.cmd, op.data[7:4]};
                                wr_idx_next = wr_idx_inc;
                                lo_load     = 1'b1;
                                state_next  = ST_WR_LO;
                            end
                            else
                            begin
                                res_load = 1'b1;
                            end
                        end
                        lcdq_pkg::OP_TICK:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_re      = 1'b1;
                                rd_idx_next = rd_idx_inc;
                                count_next  = count_reg - lcdq_pkg::LVL_W'(1);
                                state_next  = ST_RD;
                            end
                            else
                            begin
                                res_load = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_WR_LO:
            begin
                mem_we      = 1'b1;
                mem_wdata   = lo_entry_reg;
                wr_idx_next = wr_idx_inc;
                count_next  = count_reg + lcdq_pkg::LVL_W'(2);
                res_load    = 1'b1;
                res_acc     = 1'b1;
                res_level   = count_reg + lcdq_pkg::LVL_W'(2);
                state_next  = ST_IDLE;
            end
            ST_RD:
            begin
                res_load   = 1'b1;
                res_strobe = 1'b1;
                res_nib    = rd_data_reg[lcdq_pkg::NIB_W-1:0];
                res_rs     = !rd_data_reg[lcdq_pkg::NIB_W];
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // nibble memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            nibble_mem[wr_idx_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= nibble_mem[rd_idx_reg];
        end
    end

    // hold the low nibble and the result payload
    always_ff @(posedge clk)
    begin
        if (lo_load)
        begin
            lo_entry_reg <= {op.cmd, op.data[3:0]};
        end
        if (res_load)
        begin
            acc_reg    <= res_acc;
            strobe_reg <= res_strobe;
            nib_reg    <= res_nib;
            rs_reg     <= res_rs;
            level_reg  <= res_level;
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = acc_reg;
    assign strobe_res  = strobe_reg;
    assign nibble      = nib_reg;
    assign reg_select  = rs_reg;
    assign queue_level = level_reg;

    `LCDQ_ASSERT(a_count_bound, count_reg <= lcdq_pkg::LVL_W'(lcdq_pkg::QUEUE_DEPTH), "nibble count above depth")
    `LCDQ_ASSERT(a_room_low, (state_reg == ST_WR_LO) |-> $past(has_room), "low nibble written without room")
    `LCDQ_ASSERT(a_slot_free, (state_reg != ST_IDLE) |-> !out_valid_reg, "result slot busy during an operation")
    `LCDQ_ASSERT(a_rd_nonempty, (state_reg == ST_RD) |-> ($past(count_reg) != '0), "read from empty queue")
    `LCDQ_ASSERT_ALWAYS(a_acc_strobe, out_valid_reg |-> !(acc_reg && strobe_reg), "accept and strobe together")

endmodule

### rtl/char_lcd_nibble_write_queue.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_queue
// Nibble queue between a character-LCD writer and a 4-bit LCD bus.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one request per beat: push a
// byte, set the cursor, or tick. Output channel (out_valid / out_stall)
// returns exactly one result beat per request, in request order.
// A push or set-cursor that finds room writes two nibble entries through the
// single write port of the nibble memory, the high one in ST_IDLE and the low
// one in ST_WR_LO. A tick that finds an entry reads it through the registered
// read port and returns it from ST_RD. A full push, an empty tick or an unused
// request code loads its result straight from ST_IDLE. Each result passes
// through the front operation queue and the back-end states into the result
// register, from which the receiver takes the beat.
// A two-entry operation queue sits between the decode front end and the back
// end, so requests keep being taken while the back end is busy.
// When the receiver stalls, the result register holds its beat; the back end
// waits and the front queue fills, after which in_stall rises.
// Reset empties both queues and clears the fill level; memory contents are
// not cleared and need not be.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lcdq_pkg::REQ_W-1:0]    req_type,
    input  logic [lcdq_pkg::BYTE_W-1:0]   byte_value,
    input  logic                          is_command,
    input  logic                          row,
    input  logic [lcdq_pkg::COL_W-1:0]    column,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          accepted,
    output logic                          strobe_res,
    output logic [lcdq_pkg::NIB_W-1:0]    nibble,
    output logic                          reg_select,
    output logic [lcdq_pkg::LVL_W-1:0]    queue_level
);

    logic          op_valid;
    logic          op_ready;
    lcdq_pkg::op_t op;

    // decode and buffer requests
    lcdq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .byte_value (byte_value),
        .is_command (is_command),
        .row        (row),
        .column     (column),
        .op_valid   (op_valid),
        .op         (op),
        .op_ready   (op_ready)
    );

    // execute on the nibble memory
    lcdq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (op_valid),
        .op          (op),
        .op_ready    (op_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .accepted    (accepted),
        .strobe_res  (strobe_res),
        .nibble      (nibble),
        .reg_select  (reg_select),
        .queue_level (queue_level)
    );

endmodule

### test/char_lcd_nibble_write_queue_tb.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_queue_tb
// Drives push, set-cursor, tick and spare requests into the LCD nibble queue
// and checks every result beat against a cycle-free model of the queue. The
// run covers the full and empty queue, column clamping, and a long receiver
// hold-off that fills the block and backs up its input.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lcdq_pkg::*;

    // spare request code: the block must leave its queue alone
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    localparam int RESET_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BEATS   = 350;
    localparam int BIAS_RUN      = 40;

    // traffic mix of the random stimulus
    localparam int MIX_FILL     = 0;
    localparam int MIX_DRAIN    = 1;
    localparam int MIX_BALANCED = 2;

    typedef struct packed {
        logic             accepted;
        logic             strobe;
        logic [NIB_W-1:0] nib;
        logic             rs;
        logic [LVL_W-1:0] level;
    } bus_beat_t;

    // ------------------------------------------------------------------------
    // Nibble queue model and the bus beats it still owes
    // ------------------------------------------------------------------------
    class lcd_bus_tracker;
        logic [ENTRY_W-1:0] entry_mem [QUEUE_DEPTH];
        int                 wr_pos;
        int                 rd_pos;
        int                 fill;
        bus_beat_t          owed_beats [$];
        int                 errors;

        function new();
            wr_pos = 0;
            rd_pos = 0;
            fill   = 0;
            errors = 0;
        endfunction

        // split a byte into two tagged nibbles, high one first
        function logic enqueue_byte(logic [BYTE_W-1:0] value, logic cmd);
            if (fill + 2 > QUEUE_DEPTH)
                return 1'b0;
            entry_mem[wr_pos] = {cmd, value[BYTE_W-1:NIB_W]};
            wr_pos = (wr_pos + 1) % QUEUE_DEPTH;
            entry_mem[wr_pos] = {cmd, value[NIB_W-1:0]};
            wr_pos = (wr_pos + 1) % QUEUE_DEPTH;
            fill += 2;
            return 1'b1;
        endfunction

        // work out the bus beat that an accepted request gives
        function void add_request(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] value,
                                  logic cmd, logic line, logic [COL_W-1:0] col);
            bus_beat_t          beat;
            logic [COL_W-1:0]   col_clamped;
            logic [BYTE_W-1:0]  addr_cmd;
            logic [ENTRY_W-1:0] entry;
            beat = '0;
            case (req)
                REQ_PUSH:
                    beat.accepted = enqueue_byte(value, cmd);
                REQ_CURSOR:
                begin
                    col_clamped = (col > MAX_COLUMN) ? MAX_COLUMN : col;
                    addr_cmd    = (line ? CURSOR_ROW1 : CURSOR_ROW0) + {2'b00, col_clamped};
                    beat.accepted = enqueue_byte(addr_cmd, 1'b1);
                end
                REQ_TICK:
                begin
                    if (fill != 0)
                    begin
                        entry       = entry_mem[rd_pos];
                        rd_pos      = (rd_pos + 1) % QUEUE_DEPTH;
                        fill       -= 1;
                        beat.strobe = 1'b1;
                        beat.nib    = entry[NIB_W-1:0];
                        beat.rs     = ~entry[NIB_W];
                    end
                end
                default:
                    ;
            endcase
            beat.level = LVL_W'(fill);
            owed_beats.push_back(beat);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // match a result beat against the oldest owed one
        function void check_bus_beat(bus_beat_t got);
            bus_beat_t want;
            if (owed_beats.size() == 0)
            begin
                $display("%0t: result beat with nothing owed, got %p", $time, got);
                errors++;
                return;
            end
            want = owed_beats.pop_front();
            if ($isunknown(got))
            begin
                $display("%0t: unknown bits in result, expected %p, got %p", $time, want, got);
                errors++;
                return;
            end
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("strobe_res", want.strobe, got.strobe);
            compare_field("nibble", want.nib, got.nib);
            compare_field("reg_select", want.rs, got.rs);
            compare_field("queue_level", want.level, got.level);
        endfunction
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type   = '0;
    logic [BYTE_W-1:0]   byte_value = '0;
    logic                is_command = 1'b0;
    logic                row        = 1'b0;
    logic [COL_W-1:0]    column     = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic                accepted;
    logic                strobe_res;
    logic [NIB_W-1:0]    nibble;
    logic                reg_select;
    logic [LVL_W-1:0]    queue_level;

    lcd_bus_tracker tracker = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    always #1 clk = ~clk;

    char_lcd_nibble_write_queue u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .byte_value  (byte_value),
        .is_command  (is_command),
        .row         (row),
        .column      (column),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .accepted    (accepted),
        .strobe_res  (strobe_res),
        .nibble      (nibble),
        .reg_select  (reg_select),
        .queue_level (queue_level)
    );

    // ------------------------------------------------------------------------
    // Receiver: random stall, or a long hold-off when one is asked for
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_asked != hold_served)
        begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // check each result beat as it is taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_bus_beat({accepted, strobe_res, nibble, reg_select, queue_level});
    end

    // end the run if the block hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("char_lcd_nibble_write_queue_tb failed");
        $finish;
    end

    // offer one request beat and hold it until the block takes it;
    // entered and left at a falling edge
    task automatic send_request(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] value,
                                logic cmd, logic line, logic [COL_W-1:0] col);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        byte_value <= value;
        is_command <= cmd;
        row        <= line;
        column     <= col;
        do
            @(posedge clk);
        while (in_stall);
        tracker.add_request(req, value, cmd, line, col);
        @(negedge clk);
    endtask

    // random request with fresh payload; the mix decides how the level drifts
    task automatic send_random(int mix);
        int               pick;
        int               push_lim;
        int               cursor_lim;
        logic [REQ_W-1:0] req;
        logic [COL_W-1:0] col;
        pick = $urandom_range(99);
        case (mix)
            MIX_FILL:  begin push_lim = 60; cursor_lim = 85; end
            MIX_DRAIN: begin push_lim = 12; cursor_lim = 20; end
            default:   begin push_lim = 35; cursor_lim = 50; end
        endcase
        if (pick < 3)
            req = REQ_SPARE;
        else if (pick < push_lim)
            req = REQ_PUSH;
        else if (pick < cursor_lim)
            req = REQ_CURSOR;
        else
            req = REQ_TICK;
        // mostly on-screen columns, some beyond the line
        if ($urandom_range(3) == 0)
            col = COL_W'($urandom_range(63));
        else
            col = COL_W'($urandom_range(39));
        send_request(req, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), col);
    endtask

    task automatic run_random(int beats);
        int mix;
        mix = MIX_BALANCED;
        for (int i = 0; i < beats; i++)
        begin
            if (i % BIAS_RUN == 0)
                mix = $urandom_range(2);
            send_random(mix);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty tick, byte extremes, cursor corners and clamping
        send_request(REQ_TICK, 8'h00, 1'b0, 1'b0, 6'd0);
        send_request(REQ_PUSH, 8'h00, 1'b0, 1'b0, 6'd0);
        send_request(REQ_PUSH, 8'hFF, 1'b1, 1'b1, 6'd63);
        send_request(REQ_CURSOR, 8'hFF, 1'b0, 1'b0, 6'd0);
        send_request(REQ_CURSOR, 8'h00, 1'b0, 1'b1, 6'd39);
        send_request(REQ_CURSOR, 8'h00, 1'b1, 1'b1, 6'd63);
        send_request(REQ_CURSOR, 8'h00, 1'b0, 1'b0, 6'd40);
        send_request(REQ_SPARE, 8'hA5, 1'b1, 1'b1, 6'd21);
        repeat (13) send_request(REQ_TICK, 8'h00, 1'b0, 1'b0, 6'd0);
        send_request(REQ_PUSH, 8'h5A, 1'b0, 1'b0, 6'd0);
        repeat (2) send_request(REQ_TICK, 8'hFF, 1'b1, 1'b1, 6'd63);

        // no idling on either side, then a long hold-off while pushes pile up
        send_idle_pct = 0;
        stall_pct    <= 0;
        run_random(PHASE_BEATS);
        hold_asked <= hold_asked + 1;
        repeat (40)
            send_request(REQ_PUSH, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                         1'b0, 6'd0);

        // sender idles
        send_idle_pct = 48;
        stall_pct    <= 0;
        run_random(PHASE_BEATS);

        // receiver stalls
        send_idle_pct = 0;
        stall_pct    <= 48;
        run_random(PHASE_BEATS);

        // both sides idle
        send_idle_pct = 33;
        stall_pct    <= 33;
        run_random(PHASE_BEATS);

        in_valid <= 1'b0;
        stall_pct <= 0;

        // drain owed beats, then give stray results time to show
        while (tracker.owed_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0)
            $display("char_lcd_nibble_write_queue_tb passed");
        else
            $display("char_lcd_nibble_write_queue_tb failed");
        $finish;
    end

endmodule
